// ===== rtl/core/lifa_pkg.sv =====
// ----------------------------------------------------------------------------
// lifa_pkg: shared constants and types for the life automaton step block
// Grid geometry, command and register codes, row and column types.
// ----------------------------------------------------------------------------
package lifa_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);

   localparam int SIZE_W     = 7;
   localparam int CMD_W      = 2;
   localparam int CELL_ROW_W = 6;
   localparam int CELL_COL_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int NBR_W      = 4;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WRAP = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // B3/S23
   localparam logic [NBR_W-1:0] SURVIVE_MIN = 4'd2;
   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;

   typedef logic [MAX_COLS-1:0] row_type;

   typedef struct packed {
      logic [CCNT_W-1:0] cols;
      logic              wrap;
   } col_cfg_type;

endpackage

// ===== rtl/core/lifa_if.sv =====
// ----------------------------------------------------------------------------
// lifa_if: channel interfaces of the life automaton step block
// Command, response and register write channels, valid/ready per beat.
// ----------------------------------------------------------------------------
interface lifa_req_if;
   import lifa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [CELL_ROW_W-1:0] cell_row;
   logic [CELL_COL_W-1:0] cell_col;
   logic                  alive_in;
   modport source (output valid, cmd, cell_row, cell_col, alive_in, input ready);
   modport sink   (input valid, cmd, cell_row, cell_col, alive_in, output ready);
endinterface

interface lifa_rsp_if;
   logic valid;
   logic ready;
   logic alive_out;
   logic status;
   modport source (output valid, alive_out, status, input ready);
   modport sink   (input valid, alive_out, status, output ready);
endinterface

interface lifa_csr_if;
   import lifa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SIZE_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lifa_row_cell.sv =====
// ----------------------------------------------------------------------------
// lifa_row_cell: one stage of the row ring
// Holds one grid row and takes its neighbor's row on every clock.
// ----------------------------------------------------------------------------
module lifa_row_cell (
   input  logic              clock,
   input  logic              reset,
   input  lifa_pkg::row_type row_in,
   output lifa_pkg::row_type row_out
);
   import lifa_pkg::*;

   row_type row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

// ===== rtl/core/lifa_row_rule.sv =====
// ----------------------------------------------------------------------------
// lifa_row_rule: next generation of one row
// Counts the eight neighbors of every column from three old rows and applies
// B3/S23; columns beyond the active width pass through unchanged.
// ----------------------------------------------------------------------------
module lifa_row_rule (
   input  lifa_pkg::row_type     above,
   input  lifa_pkg::row_type     center,
   input  lifa_pkg::row_type     below,
   input  lifa_pkg::col_cfg_type col_cfg,
   output lifa_pkg::row_type     next_row
);
   import lifa_pkg::*;

   logic [COL_W-1:0] last_col;

   assign last_col = COL_W'(col_cfg.cols - 1'b1);

   always_comb begin
      logic             la, lc, lb, ra, rc, rb;
      logic [NBR_W-1:0] n;
      next_row = center;
      for (int c = 0; c < MAX_COLS; c++) begin
         if (c == 0) begin
            la = col_cfg.wrap & above[last_col];
            lc = col_cfg.wrap & center[last_col];
            lb = col_cfg.wrap & below[last_col];
         end else begin
            la = above[c-1];
            lc = center[c-1];
            lb = below[c-1];
         end
         // right edge of the active area: wrap to column zero or dead
         if (COL_W'(c) == last_col) begin
            ra = col_cfg.wrap & above[0];
            rc = col_cfg.wrap & center[0];
            rb = col_cfg.wrap & below[0];
         end else if (c < MAX_COLS - 1) begin
            ra = above[c+1];
            rc = center[c+1];
            rb = below[c+1];
         end else begin
            ra = 1'b0;
            rc = 1'b0;
            rb = 1'b0;
         end
         n = NBR_W'(la) + NBR_W'(above[c]) + NBR_W'(ra) + NBR_W'(lc) + NBR_W'(rc)
           + NBR_W'(lb) + NBR_W'(below[c]) + NBR_W'(rb);
         if (COL_W'(c) <= last_col) begin
            if (center[c]) begin
               next_row[c] = (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
            end else begin
               next_row[c] = (n == BIRTH_COUNT);
            end
         end
      end
   end

endmodule

// ===== rtl/core/life_automaton_step.sv =====
// ----------------------------------------------------------------------------
// life_automaton_step: B3/S23 cell store with row-ring generation engine
// Grid rows circulate through a ring of row cells; the head row is read,
// written or replaced by its next generation as it passes.
// ----------------------------------------------------------------------------
// Operation: read/write wait for the row at the ring head; generation
//   seeks the last active row, then writes back one row per cycle around
//   the ring; errors skip the ring and go straight to the response.
// Throughput: one command at a time, bounded by the ring rotation.
// Reset: all cells dead at once, sizes 64 x 64, dead borders.
module life_automaton_step (
   input  logic       clock,
   input  logic       reset,
   lifa_req_if.sink   req_ch,
   lifa_rsp_if.source rsp_ch,
   lifa_csr_if.sink   csr_ch
);
   import lifa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEEK  = 3'd1;
   localparam logic [2:0] S_LAST  = 3'd2;
   localparam logic [2:0] S_WAIT0 = 3'd3;
   localparam logic [2:0] S_GEN   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SIZE_W-1:0] rows_ff, cols_ff;
   logic              wrap_ff;
   logic [ROW_W-1:0]  head_ff, head_in;

   logic [CMD_W-1:0]  op_cmd_ff, op_cmd_in;
   logic [ROW_W-1:0]  op_row_ff, op_row_in;
   logic [COL_W-1:0]  op_col_ff, op_col_in;
   logic              op_val_ff, op_val_in;
   logic              res_alive_ff, res_alive_in;
   logic              res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_alive_ff, rsp_alive_in;
   logic              rsp_status_ff, rsp_status_in;

   row_type           last_old_ff, last_old_in;
   row_type           prev_old_ff, prev_old_in;
   row_type           first_old_ff, first_old_in;

   row_type           ring_q [MAX_ROWS];
   row_type           ring_d [MAX_ROWS];
   row_type           cur_row, wb_row, above, below, gen_row;

   logic [RCNT_W-1:0] nr;
   logic [CCNT_W-1:0] nc;
   logic [ROW_W-1:0]  last_row;
   col_cfg_type       col_cfg;
   logic              req_beat, out_free, in_range;

   // size registers: zero acts as one, large values saturate
   assign nr = (rows_ff == '0) ? RCNT_W'(1) :
               (int'(rows_ff) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_ff);
   assign nc = (cols_ff == '0) ? CCNT_W'(1) :
               (int'(cols_ff) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_ff);
   assign last_row     = ROW_W'(nr - 1'b1);
   assign col_cfg.cols = nc;
   assign col_cfg.wrap = wrap_ff;

   // row ring: stage i takes stage i+1, the tail takes the write-back row
   genvar gi;
   for (gi = 0; gi < MAX_ROWS; gi++) begin : g_ring
      if (gi == MAX_ROWS - 1) begin : g_tail
         assign ring_d[gi] = wb_row;
      end else begin : g_body
         assign ring_d[gi] = ring_q[gi+1];
      end
      lifa_row_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .row_in  (ring_d[gi]),
         .row_out (ring_q[gi])
      );
   end

   assign cur_row = ring_q[0];
   assign head_in = (head_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : ROW_W'(head_ff + 1'b1);

   // neighbor rows of the head row, all from the old grid
   always_comb begin
      if (head_ff == '0) begin
         above = wrap_ff ? last_old_ff : '0;
      end else begin
         above = prev_old_ff;
      end
      if (head_ff == last_row) begin
         if (!wrap_ff) begin
            below = '0;
         end else if (head_ff == '0) begin
            below = cur_row;
         end else begin
            below = first_old_ff;
         end
      end else begin
         below = ring_q[1];
      end
   end

   lifa_row_rule u_rule (
      .above    (above),
      .center   (cur_row),
      .below    (below),
      .col_cfg  (col_cfg),
      .next_row (gen_row)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign in_range     = (int'(req_ch.cell_row) < int'(nr)) &&
                         (int'(req_ch.cell_col) < int'(nc));

   always_comb begin
      state_in      = state_ff;
      op_cmd_in     = op_cmd_ff;
      op_row_in     = op_row_ff;
      op_col_in     = op_col_ff;
      op_val_in     = op_val_ff;
      res_alive_in  = res_alive_ff;
      res_status_in = res_status_ff;
      last_old_in   = last_old_ff;
      prev_old_in   = prev_old_ff;
      first_old_in  = first_old_ff;
      wb_row        = cur_row;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_alive_in  = rsp_alive_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_cmd_in     = req_ch.cmd;
               op_row_in     = ROW_W'(req_ch.cell_row);
               op_col_in     = COL_W'(req_ch.cell_col);
               op_val_in     = req_ch.alive_in;
               res_alive_in  = 1'b0;
               res_status_in = 1'b0;
               case (req_ch.cmd)
                  CMD_WRITE, CMD_READ: begin
                     if (in_range) begin
                        state_in = S_SEEK;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = S_DONE;
                     end
                  end
                  CMD_STEP: begin
                     state_in = S_LAST;
                  end
                  default: begin
                     res_status_in = 1'b1;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SEEK: begin
            if (head_ff == op_row_ff) begin
               if (op_cmd_ff == CMD_READ) begin
                  res_alive_in = cur_row[op_col_ff];
               end else begin
                  wb_row[op_col_ff] = op_val_ff;
               end
               state_in = S_DONE;
            end
         end
         S_LAST: begin
            // grab the old last row for the wrap of row zero
            if (head_ff == last_row) begin
               last_old_in = cur_row;
               state_in    = (head_in == '0) ? S_GEN : S_WAIT0;
            end
         end
         S_WAIT0: begin
            if (head_in == '0) begin
               state_in = S_GEN;
            end
         end
         S_GEN: begin
            wb_row      = gen_row;
            prev_old_in = cur_row;
            if (head_ff == '0) begin
               first_old_in = cur_row;
            end
            if (head_ff == last_row) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_alive_in  = res_alive_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= SIZE_RESET;
         cols_ff      <= SIZE_RESET;
         wrap_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_ROWS: rows_ff <= csr_ch.data;
               REG_COLS: cols_ff <= csr_ch.data;
               REG_WRAP: wrap_ff <= csr_ch.data[0];
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_cmd_ff     <= op_cmd_in;
      op_row_ff     <= op_row_in;
      op_col_ff     <= op_col_in;
      op_val_ff     <= op_val_in;
      res_alive_ff  <= res_alive_in;
      res_status_ff <= res_status_in;
      last_old_ff   <= last_old_in;
      prev_old_ff   <= prev_old_in;
      first_old_ff  <= first_old_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.alive_out = rsp_alive_ff;
   assign rsp_ch.status    = rsp_status_ff;

   // an error beat never carries a live cell
   a_err_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> !rsp_alive_ff)
      else $error("error response with alive_out set");

   // the seek ends on the cycle its row reaches the ring head
   a_seek_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEEK) && (head_ff == op_row_ff) |=> (state_ff == S_DONE))
      else $error("seek missed its row");

   // a finished command goes out as soon as the output slot frees
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready)
      |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished command not delivered");

endmodule
